// ===== sv/npbi_pkg.sv =====
`default_nettype none

package npbi_pkg;

  // Palette size; any value from 2 to 256.
  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam int unsigned ADDR_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned RGB_W   = 3 * CHAN_W;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned COST_W  = SQ_W + 2;
  localparam int unsigned LIMIT_W = IDX_W + 1;

  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT = LIMIT_W'(PALETTE_ENTRIES);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_NEAREST = 2'd1,
    REQ_BLEND   = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_e;

  typedef logic [RGB_W-1:0] rgb_t;

endpackage

`default_nettype wire

// ===== sv/npbi_ram.sv =====
`default_nettype none

module npbi_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [$clog2(DEPTH)-1:0]    waddr_i,
  input  wire  [WIDTH-1:0]            wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [WIDTH-1:0]            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/nearest_palette_blend_index_top.sv =====
`default_nettype none

// Nearest palette color search with a fixed 25/75 blend request.
// Requests enter on start_i and are taken at an edge where start_i is high
// and busy_o is low. req_type_i selects the request:
//   load    - writes red/green/blue into slot entry_index_i,
//             busy_o stays low and no result is produced.
//   nearest - scans the palette for the entry closest to red/green/blue
//             (sum of squared channel differences, lowest index on a tie).
//   blend   - equal fg/bg indices return that index in the next cycle with no
//             scan; otherwise fg and bg are read, mixed as (fg + 3*bg) / 4
//             per channel and the mixed color is searched like a nearest.
//   The unused code is dropped without a result.
// Each result shows on palette_index_o for one cycle with result_valid_o.
// The receiver cannot stall: results are never held.
// Timing: the palette memory has one read port and the scan reads one entry
// per cycle, so busy_o stays high while a nearest request scans the palette;
// a blend first steps through the fg read, bg read and mix states and then
// scans. The result strobe comes in the first cycle busy_o is low again, so
// the next request may be taken in that same cycle.
// Reset clears the control state only; the palette is undefined until every
// slot is loaded, which must happen before the first query.

module nearest_palette_blend_index_top
  import npbi_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire  [1:0]        req_type_i,
  input  wire  [IDX_W-1:0]  entry_index_i,
  input  wire  [CHAN_W-1:0] red_i,
  input  wire  [CHAN_W-1:0] green_i,
  input  wire  [CHAN_W-1:0] blue_i,
  input  wire  [IDX_W-1:0]  fg_index_i,
  input  wire  [IDX_W-1:0]  bg_index_i,
  output logic [IDX_W-1:0]  palette_index_o,
  output logic              result_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FG,
    ST_RD_BG,
    ST_MIX,
    ST_SCAN
  } state_e;

  // Control registers.
  state_e            state_q, state_d;
  logic              issue_q, issue_d;
  logic [ADDR_W-1:0] scan_addr_q, scan_addr_d;
  logic              s0_valid_q, s0_valid_d;
  logic              s0_last_q, s0_last_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q, s1_last_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers.
  logic [IDX_W-1:0]  out_index_q, out_index_d;
  logic [COST_W-1:0] best_cost_q, best_cost_d;
  logic [ADDR_W-1:0] best_idx_q, best_idx_d;
  logic [ADDR_W-1:0] s0_idx_q;
  logic [ADDR_W-1:0] s1_idx_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  rgb_t              target_q, target_d;
  rgb_t              fg_rgb_q, fg_rgb_d;
  logic [IDX_W-1:0]  fg_idx_q, fg_idx_d;
  logic [IDX_W-1:0]  bg_idx_q, bg_idx_d;
  logic              fg_ok_q, fg_ok_d;
  logic              bg_ok_q, bg_ok_d;

  logic              accept;
  req_type_e         req;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  rgb_t              ram_rdata;
  rgb_t              bg_rgb;
  rgb_t              mix_rgb;
  logic [COST_W-1:0] cost;
  logic              better;
  logic [SQ_W-1:0]   sq_r_d, sq_g_d, sq_b_d;

  assign accept = start_i && !busy_o;
  assign req    = req_type_e'(req_type_i);
  assign busy_o = (state_q != ST_IDLE);

  assign ram_we = accept && (req == REQ_LOAD) && ({1'b0, entry_index_i} < ENTRY_LIMIT);

  // Port sharing: blend operand reads, otherwise the scan address.
  always_comb begin
    case (state_q)
      ST_RD_FG: ram_raddr = fg_idx_q[ADDR_W-1:0];
      ST_RD_BG: ram_raddr = bg_idx_q[ADDR_W-1:0];
      default:  ram_raddr = scan_addr_q;
    endcase
  end

  npbi_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i[ADDR_W-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // 25*fg + 75*bg over 100 reduces exactly to (fg + 3*bg) / 4.
  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] f,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W+1:0] sum;
    sum = {2'b00, f} + {1'b0, b, 1'b0} + {2'b00, b};
    mix_chan = sum[CHAN_W+1:2];
  endfunction

  // Stage 1: squared channel distances of the entry that just came back.
  always_comb begin
    logic [CHAN_W-1:0] dr, dg, db;
    dr = abs_diff(target_q[23:16], ram_rdata[23:16]);
    dg = abs_diff(target_q[15:8],  ram_rdata[15:8]);
    db = abs_diff(target_q[7:0],   ram_rdata[7:0]);
    sq_r_d = dr * dr;
    sq_g_d = dg * dg;
    sq_b_d = db * db;
  end

  // Stage 2: total cost and strict compare, so the lowest index wins ties.
  assign cost   = COST_W'(sq_r_q) + COST_W'(sq_g_q) + COST_W'(sq_b_q);
  assign better = (cost < best_cost_q);

  assign bg_rgb  = bg_ok_q ? ram_rdata : '0;
  assign mix_rgb = {mix_chan(fg_rgb_q[23:16], bg_rgb[23:16]),
                    mix_chan(fg_rgb_q[15:8],  bg_rgb[15:8]),
                    mix_chan(fg_rgb_q[7:0],   bg_rgb[7:0])};

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    scan_addr_d = scan_addr_q;
    s0_valid_d  = 1'b0;
    s0_last_d   = 1'b0;
    s1_valid_d  = s0_valid_q;
    s1_last_d   = s0_last_q;
    out_valid_d = 1'b0;
    out_index_d = out_index_q;
    best_cost_d = best_cost_q;
    best_idx_d  = best_idx_q;
    target_d    = target_q;
    fg_rgb_d    = fg_rgb_q;
    fg_idx_d    = fg_idx_q;
    bg_idx_d    = bg_idx_q;
    fg_ok_d     = fg_ok_q;
    bg_ok_d     = bg_ok_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_NEAREST: begin
              target_d    = {red_i, green_i, blue_i};
              state_d     = ST_SCAN;
              issue_d     = 1'b1;
              scan_addr_d = '0;
              best_cost_d = '1;
            end
            REQ_BLEND: begin
              if (fg_index_i == bg_index_i) begin
                out_valid_d = 1'b1;
                out_index_d = fg_index_i;
              end else begin
                fg_idx_d = fg_index_i;
                bg_idx_d = bg_index_i;
                fg_ok_d  = ({1'b0, fg_index_i} < ENTRY_LIMIT);
                bg_ok_d  = ({1'b0, bg_index_i} < ENTRY_LIMIT);
                state_d  = ST_RD_FG;
              end
            end
            default: begin
              // Load is written straight to memory; drop the unused code.
            end
          endcase
        end
      end
      ST_RD_FG: begin
        state_d = ST_RD_BG;
      end
      ST_RD_BG: begin
        fg_rgb_d = fg_ok_q ? ram_rdata : '0;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        target_d    = mix_rgb;
        state_d     = ST_SCAN;
        issue_d     = 1'b1;
        scan_addr_d = '0;
        best_cost_d = '1;
      end
      ST_SCAN: begin
        if (issue_q) begin
          s0_valid_d = 1'b1;
          s0_last_d  = (scan_addr_q == LAST_ADDR);
          if (scan_addr_q == LAST_ADDR) begin
            issue_d = 1'b0;
          end else begin
            scan_addr_d = scan_addr_q + 1'b1;
          end
        end
        if (s1_valid_q) begin
          if (better) begin
            best_cost_d = cost;
            best_idx_d  = s1_idx_q;
          end
          if (s1_last_q) begin
            out_valid_d = 1'b1;
            out_index_d = better ? IDX_W'(s1_idx_q) : IDX_W'(best_idx_q);
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      scan_addr_q <= '0;
      s0_valid_q  <= 1'b0;
      s0_last_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      scan_addr_q <= scan_addr_d;
      s0_valid_q  <= s0_valid_d;
      s0_last_q   <= s0_last_d;
      s1_valid_q  <= s1_valid_d;
      s1_last_q   <= s1_last_d;
      out_valid_q <= out_valid_d;
      out_index_q <= out_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_cost_q <= best_cost_d;
    best_idx_q  <= best_idx_d;
    target_q    <= target_d;
    fg_rgb_q    <= fg_rgb_d;
    fg_idx_q    <= fg_idx_d;
    bg_idx_q    <= bg_idx_d;
    fg_ok_q     <= fg_ok_d;
    bg_ok_q     <= bg_ok_d;
    s0_idx_q    <= scan_addr_q;
    s1_idx_q    <= s0_idx_q;
    sq_r_q      <= sq_r_d;
    sq_g_q      <= sq_g_d;
    sq_b_q      <= sq_b_d;
  end

  assign palette_index_o = out_index_q;
  assign result_valid_o  = out_valid_q;

  // Palette writes only happen while no query is in flight.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("palette write during a query");

  // Scan pipeline data only exists while scanning.
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q || s1_valid_q) |-> (state_q == ST_SCAN))
    else $error("scan pipeline active outside scan");

  // A result strobe always coincides with the block being free again.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result shown while busy");

  // A scan that starts issuing begins at the first palette slot.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(issue_q) |-> (scan_addr_q == '0))
    else $error("scan started at a nonzero slot");

endmodule

`default_nettype wire
